// ===== hdl/grw_pkg.sv =====
package grw_pkg;

    localparam int NODES  = 64;
    localparam int NODE_W = 6;
    localparam int ADJ_AW = $clog2(NODES);

    localparam logic [63:0] NODE_MASK = (NODES >= 64) ? {64{1'b1}}
                                                      : ((64'd1 << NODES) - 64'd1);

    typedef enum logic {
        OP_EDGE = 1'b0,
        OP_SEED = 1'b1
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [NODE_W-1:0] src_node;
        logic [NODE_W-1:0] dst_node;
        logic              last_seed;
    } t_in;

    typedef struct packed {
        logic [NODE_W-1:0] reached_node;
        logic              last;
    } t_out;

    // Edge write request into the adjacency store.
    typedef struct packed {
        logic              vld;
        logic [NODE_W-1:0] src;
        logic [NODE_W-1:0] dst;
    } t_edge_req;

    // Row read request from the walk.
    typedef struct packed {
        logic              vld;
        logic [NODE_W-1:0] node;
    } t_row_rd;

    typedef struct packed {
        logic              found;
        logic [NODE_W-1:0] idx;
    } t_pick;

    // Lowest set bit of a node bitmap.
    function automatic t_pick lowest(input logic [63:0] v);
        t_pick p;
        p.found = 1'b0;
        p.idx   = '0;
        for (int i = 63; i >= 0; i--) begin
            if (v[i]) begin
                p.found = 1'b1;
                p.idx   = NODE_W'(i);
            end
        end
        return p;
    endfunction

endpackage

// ===== hdl/graph_reachability_walk.sv =====
// Reachability search over a directed graph of up to 64 nodes.
//
// Input channel: drive i_item and raise start; the transaction is taken at a
// clock edge where start is high and busy is low. An edge item (op 0) adds
// src_node -> dst_node to the adjacency memory; a seed item (op 1) adds a node
// to the seed set. Edge and seed items are taken every cycle while busy is low.
// A seed item with last_seed set launches a walk, and busy stays high until
// the last result is out.
// Walk: one adjacency row read per reached node through the single read port
// of the adjacency memory, pipelined: a new row read can issue before the
// last row has come back. Emit then gives one node id per cycle in ascending
// order on o_result, with o_strobe high for that one cycle; the last one has
// o_result.last set. An empty seed set gives no results; busy passes through
// the walk and emit states. The receiver cannot stall; results are never held.
// Reset: synchronous, active low; the graph, seed set and walk state are
// cleared at once (row valid bits mark adjacency rows never written as empty).
module graph_reachability_walk (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  grw_pkg::t_in  i_item,
    output logic          busy,
    output logic          o_strobe,
    output grw_pkg::t_out o_result
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state        r_state, n_state;
    logic [63:0]   r_seed, n_seed;
    logic [63:0]   r_visited, n_visited;
    logic [63:0]   r_frontier, n_frontier;
    logic          r_rd_pend, n_rd_pend;
    logic          r_strobe, n_strobe;
    grw_pkg::t_out r_result, n_result;

    logic               accept;
    grw_pkg::t_edge_req edge_req;
    grw_pkg::t_row_rd   row_rd;
    logic [63:0]        row;
    logic [63:0]        merged;
    logic [63:0]        seed_bit;
    logic [63:0]        rest;
    grw_pkg::t_pick     pick;

    assign busy   = (r_state != S_IDLE);
    assign accept = start & ~busy;

    // Drop edges with an end outside the graph.
    always_comb begin
        edge_req.vld = accept && (i_item.op == grw_pkg::OP_EDGE)
                       && (int'(i_item.src_node) < grw_pkg::NODES)
                       && (int'(i_item.dst_node) < grw_pkg::NODES);
        edge_req.src = i_item.src_node;
        edge_req.dst = i_item.dst_node;
    end

    grw_adj u_adj (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_edge  (edge_req),
        .i_row_rd(row_rd),
        .o_row   (row)
    );

    always_comb begin
        n_state    = r_state;
        n_seed     = r_seed;
        n_visited  = r_visited;
        n_frontier = r_frontier;
        n_rd_pend  = 1'b0;
        n_strobe   = 1'b0;
        n_result   = r_result;
        row_rd.vld  = 1'b0;
        row_rd.node = '0;
        seed_bit    = '0;
        merged      = r_frontier;
        rest        = r_visited;
        pick        = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_item.op == grw_pkg::OP_SEED)) begin
                    if (int'(i_item.src_node) < grw_pkg::NODES) begin
                        seed_bit = 64'd1 << i_item.src_node;
                    end
                    n_seed = r_seed | seed_bit;
                    if (i_item.last_seed) begin
                        // Launch the walk from the full seed set.
                        n_frontier = n_seed & grw_pkg::NODE_MASK;
                        n_visited  = '0;
                        n_seed     = '0;
                        n_state    = S_WALK;
                    end
                end
            end
            S_WALK: begin
                // Merge the row that just came back, then visit the lowest node.
                if (r_rd_pend) begin
                    merged = r_frontier | (row & grw_pkg::NODE_MASK & ~r_visited);
                end
                pick       = grw_pkg::lowest(merged);
                n_frontier = merged;
                if (pick.found) begin
                    n_frontier  = merged & ~(64'd1 << pick.idx);
                    n_visited   = r_visited | (64'd1 << pick.idx);
                    row_rd.vld  = 1'b1;
                    row_rd.node = pick.idx;
                    n_rd_pend   = 1'b1;
                end else if (!r_rd_pend) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                pick = grw_pkg::lowest(r_visited);
                rest = r_visited & ~(64'd1 << pick.idx);
                if (pick.found) begin
                    n_strobe              = 1'b1;
                    n_result.reached_node = pick.idx;
                    n_result.last         = (rest == 64'd0);
                    n_visited             = rest;
                    if (rest == 64'd0) begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_seed     <= '0;
            r_visited  <= '0;
            r_frontier <= '0;
            r_rd_pend  <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_seed     <= n_seed;
            r_visited  <= n_visited;
            r_frontier <= n_frontier;
            r_rd_pend  <= n_rd_pend;
            r_strobe   <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// ===== hdl/grw_ram.sv =====
module grw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/grw_adj.sv =====
module grw_adj (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  grw_pkg::t_edge_req i_edge,
    input  grw_pkg::t_row_rd   i_row_rd,
    output logic [63:0]        o_row
);

    logic [grw_pkg::NODES-1:0]  r_row_vld;
    logic                       r_s1_vld;
    logic [grw_pkg::NODE_W-1:0] r_s1_src;
    logic [grw_pkg::NODE_W-1:0] r_s1_dst;
    logic                       r_s1_rowvld;
    logic                       r_fwd_vld;
    logic [grw_pkg::NODE_W-1:0] r_fwd_addr;
    logic [63:0]                r_fwd_data;

    logic                       rd_en;
    logic [grw_pkg::NODE_W-1:0] rd_node;
    logic [63:0]                rd_data;
    logic [63:0]                row_q;
    logic [63:0]                base;
    logic [63:0]                wr_data;

    // Walk reads never overlap edge traffic; give them the port anyway.
    assign rd_en   = i_row_rd.vld | i_edge.vld;
    assign rd_node = i_row_rd.vld ? i_row_rd.node : i_edge.src;

    grw_ram #(
        .WIDTH(64),
        .DEPTH(grw_pkg::NODES)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (r_s1_vld),
        .i_waddr(r_s1_src[grw_pkg::ADJ_AW-1:0]),
        .i_wdata(wr_data),
        .i_re   (rd_en),
        .i_raddr(rd_node[grw_pkg::ADJ_AW-1:0]),
        .o_rdata(rd_data)
    );

    // A row never written reads as empty.
    assign row_q = r_s1_rowvld ? rd_data : 64'd0;

    // Forward the previous write when it hit the row now being merged.
    always_comb begin
        if (r_fwd_vld && (r_fwd_addr == r_s1_src)) begin
            base = r_fwd_data;
        end else begin
            base = row_q;
        end
        wr_data = base | (64'd1 << r_s1_dst);
    end

    assign o_row = row_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_s1_vld  <= 1'b0;
            r_fwd_vld <= 1'b0;
        end else begin
            r_s1_vld  <= i_edge.vld & ~i_row_rd.vld;
            r_fwd_vld <= r_s1_vld;
            if (r_s1_vld) begin
                r_row_vld[r_s1_src[grw_pkg::ADJ_AW-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_src    <= rd_node;
        r_s1_dst    <= i_edge.dst;
        r_s1_rowvld <= r_row_vld[rd_node[grw_pkg::ADJ_AW-1:0]];
        r_fwd_addr  <= r_s1_src;
        r_fwd_data  <= wr_data;
    end

endmodule
